// File: src/bsct_pkg.sv
// Shared constants, types and helpers for the bounding sphere / cone transform.
`default_nettype none

package bsct_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int IN_TDATA_W  = 384;
    localparam int OUT_TDATA_W = 248;
    localparam int OUT_PAD_W   = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CENTRE_X = 3'd0;
    localparam t_cfg_idx CFG_CENTRE_Y = 3'd1;
    localparam t_cfg_idx CFG_CENTRE_Z = 3'd2;
    localparam t_cfg_idx CFG_RADIUS   = 3'd3;
    localparam t_cfg_idx CFG_AXIS_X   = 3'd4;
    localparam t_cfg_idx CFG_AXIS_Y   = 3'd5;
    localparam t_cfg_idx CFG_AXIS_Z   = 3'd6;
    localparam t_cfg_idx CFG_COSINE   = 3'd7;

    localparam logic signed [17:0] AXIS_Z_RST = 18'sd65536;
    localparam logic signed [17:0] COSINE_RST = -18'sd65536;

    // Clamp a wide signed value to the 32 bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/bsct_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
`default_nettype none

module bsct_isqrt #(
    parameter int IN_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [IN_W-1:0]   i_rad,
    output logic      [IN_W/2-1:0] o_root
);

    localparam int OW = IN_W / 2;
    localparam int RW = OW + 1;
    localparam int TW = OW + 3;

    logic [RW-1:0]   r_rem  [OW];
    logic [OW-1:0]   r_root [OW];
    logic [IN_W-1:0] r_rest [OW];

    for (genvar g = 0; g < OW; g++) begin : g_stage
        logic [RW-1:0]   w_rem_in;
        logic [OW-1:0]   w_root_in;
        logic [IN_W-1:0] w_rest_in;
        logic [TW-1:0]   w_tmp;
        logic [TW-1:0]   w_trial;

        if (g == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rest_in = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
            assign w_rest_in = r_rest[g-1];
        end

        // bring down the next two radicand bits and try the next root bit
        assign w_tmp   = {w_rem_in, w_rest_in[IN_W-1 -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_tmp >= w_trial) begin
                    r_rem[g]  <= RW'(w_tmp - w_trial);
                    r_root[g] <= {w_root_in[OW-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= RW'(w_tmp);
                    r_root[g] <= {w_root_in[OW-2:0], 1'b0};
                end
                r_rest[g] <= {w_rest_in[IN_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[OW-1];

endmodule

`default_nettype wire

// File: src/bsct_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module bsct_div #(
    parameter int VW = 32,
    parameter int QW = 17
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [VW+QW-1:0] i_dvd,
    input  wire logic [VW-1:0]    i_dvs,
    output logic      [QW-1:0]    o_quo
);

    // The upper VW dividend bits must already be below the divisor.
    logic [VW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [VW-1:0] r_dvs [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [VW-1:0] w_rem_in;
        logic [QW-1:0] w_low_in;
        logic [QW-1:0] w_quo_in;
        logic [VW-1:0] w_dvs_in;
        logic [VW:0]   w_tmp;

        if (g == 0) begin : g_first
            assign w_rem_in = i_dvd[VW+QW-1:QW];
            assign w_low_in = i_dvd[QW-1:0];
            assign w_quo_in = '0;
            assign w_dvs_in = i_dvs;
        end else begin : g_next
            assign w_rem_in = r_rem[g-1];
            assign w_low_in = r_low[g-1];
            assign w_quo_in = r_quo[g-1];
            assign w_dvs_in = r_dvs[g-1];
        end

        assign w_tmp = {w_rem_in, w_low_in[QW-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_tmp >= {1'b0, w_dvs_in}) begin
                    r_rem[g] <= VW'(w_tmp - {1'b0, w_dvs_in});
                    r_quo[g] <= {w_quo_in[QW-2:0], 1'b1};
                end else begin
                    r_rem[g] <= VW'(w_tmp);
                    r_quo[g] <= {w_quo_in[QW-2:0], 1'b0};
                end
                r_low[g] <= {w_low_in[QW-2:0], 1'b0};
                r_dvs[g] <= w_dvs_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

// File: src/bounding_sphere_cone_transform.sv
// Top level: per-instance world-space bounding sphere and normal cone.
`default_nettype none

// Takes one instance transform (upper three rows of a column-major model
// matrix, Q(32-FRAC_BITS).FRAC_BITS) per transfer on the slave stream and
// returns one culling record per transfer on the master stream, in order.
// The local sphere and cone come from the configuration registers; write
// them only while no record is in flight. The block takes one transform
// every clock cycle while the output skid stage is empty. The pipeline depth
// is set by the 32-stage square root of the rotated axis length and the
// FRAC_BITS + 1 stage normalizing divider. The column-length square roots
// run alongside. The whole pipeline holds
// when the output skid stage is full; a result waiting in the output
// register does not block new transfers by itself.
module bounding_sphere_cone_transform #(
    parameter int FRAC_BITS = bsct_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [bsct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bsct_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // slave stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z,
    // trans_x, trans_y, trans_z (32 bits each, lowest first)
    input  wire logic [bsct_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // master stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // world_centre_x/y/z (32 each), world_radius (31), world_axis_x/y/z
    // (32 each), world_cone_cosine (18), zero pad (7)
    output logic [bsct_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata
);

    import bsct_pkg::*;

    localparam int SQ    = 32;                 // square root stages
    localparam int QW    = FRAC_BITS + 1;      // quotient bits / divider stages
    localparam int DW    = 32 + QW;
    localparam int TOTAL = 7 + SQ + QW;        // last pipeline stage
    localparam int RT_W  = 64 - FRAC_BITS;     // rounded centre term width
    localparam int DC    = TOTAL - 3;          // centre delay
    localparam int DR    = QW + 3;             // radius delay
    localparam int DA    = SQ + QW + 3;        // rotated axis delay
    localparam int TAP   = SQ + 1;             // axis tap feeding the divider

    localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [51:0] HALF52 = 52'sd1 <<< (FRAC_BITS - 1);
    localparam logic        [63:0] HALFU  = 64'd1 << (FRAC_BITS - 1);
    // 1e-6 in the fixed-point format, truncated
    localparam logic        [31:0] LEN_EPS = 32'((64'd1 << FRAC_BITS) / 64'd1000000);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [31:0] r_lc [3];
    logic        [30:0] r_lrad;
    logic signed [17:0] r_la [3];
    logic signed [17:0] r_lcos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc[0] <= '0;
            r_lc[1] <= '0;
            r_lc[2] <= '0;
            r_lrad  <= '0;
            r_la[0] <= '0;
            r_la[1] <= '0;
            r_la[2] <= AXIS_Z_RST;
            r_lcos  <= COSINE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTRE_X: r_lc[0] <= i_cfg_wdata;
                CFG_CENTRE_Y: r_lc[1] <= i_cfg_wdata;
                CFG_CENTRE_Z: r_lc[2] <= i_cfg_wdata;
                CFG_RADIUS:   r_lrad  <= i_cfg_wdata[30:0];
                CFG_AXIS_X:   r_la[0] <= i_cfg_wdata[17:0];
                CFG_AXIS_Y:   r_la[1] <= i_cfg_wdata[17:0];
                CFG_AXIS_Z:   r_la[2] <= i_cfg_wdata[17:0];
                CFG_COSINE:   r_lcos  <= i_cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: global advance, output register plus skid entry
    // ---------------------------------------------------------------
    logic                   w_en;
    logic                   w_push;
    logic [TOTAL:1]         r_vld;
    logic                   r_out_vld;
    logic                   r_skid_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] r_skid_data;
    logic [OUT_TDATA_W-1:0] w_res;

    assign w_en            = !r_skid_vld;
    assign w_push          = w_en && r_vld[TOTAL];
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOTAL-1:1], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_push) begin
            // park the record in the skid entry if the output is held
            if (!r_out_vld || i_m_axis_tready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld && i_m_axis_tready) begin
            r_skid_vld <= 1'b0;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && (!r_out_vld || i_m_axis_tready)) begin
            r_out_data <= w_res;
        end else if (r_skid_vld && i_m_axis_tready) begin
            r_out_data <= r_skid_data;
        end
        if (w_push && r_out_vld && !i_m_axis_tready) begin
            r_skid_data <= w_res;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: all products
    // ---------------------------------------------------------------
    logic signed [31:0] w_m [3][3];     // column k, row i
    logic signed [31:0] w_t [3];
    logic signed [63:0] w_sqf [3][3];
    logic signed [63:0] n_pc [3][3];
    logic signed [49:0] n_pa [3][3];
    logic        [62:0] n_sq [3][3];
    logic signed [63:0] r_pc [3][3];
    logic signed [49:0] r_pa [3][3];
    logic        [62:0] r_sq [3][3];
    logic signed [31:0] r_t1 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                w_m[k][i]   = i_s_axis_tdata[32*(3*k+i) +: 32];
                n_pc[k][i]  = w_m[k][i] * r_lc[k];
                n_pa[k][i]  = w_m[k][i] * r_la[k];
                w_sqf[k][i] = w_m[k][i] * w_m[k][i];
                n_sq[k][i]  = w_sqf[k][i][62:0];
            end
            w_t[k] = i_s_axis_tdata[32*(9+k) +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc <= n_pc;
            r_pa <= n_pa;
            r_sq <= n_sq;
            r_t1 <= w_t;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: round centre terms, sum rotation and column squares
    // ---------------------------------------------------------------
    logic signed [63:0]     w_rnd [3][3];
    logic signed [RT_W-1:0] n_cr  [3][3];
    logic signed [51:0]     n_ax  [3];
    logic        [63:0]     n_cs  [3];
    logic signed [RT_W-1:0] r_cr  [3][3];  // row i, column k
    logic signed [51:0]     r_ax  [3];
    logic        [63:0]     r_cs  [3];
    logic signed [31:0]     r_t2  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                w_rnd[i][k] = r_pc[k][i] + HALF64;
                n_cr[i][k]  = RT_W'(w_rnd[i][k] >>> FRAC_BITS);
            end
            n_ax[i] = 52'(r_pa[0][i]) + 52'(r_pa[1][i]) + 52'(r_pa[2][i]);
            n_cs[i] = 64'(r_sq[i][0]) + 64'(r_sq[i][1]) + 64'(r_sq[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cr <= n_cr;
            r_ax <= n_ax;
            r_cs <= n_cs;
            r_t2 <= r_t1;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: centre sum with clamp, rounded rotated axis
    // ---------------------------------------------------------------
    logic signed [51:0] w_axr [3];
    logic signed [31:0] n_cen [3];
    logic signed [31:0] n_rot [3];
    logic signed [31:0] r_cen [3];
    logic signed [31:0] r_rot [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cen[i] = sat32(66'(r_t2[i]) + 66'(r_cr[i][0]) + 66'(r_cr[i][1])
                             + 66'(r_cr[i][2]));
            w_axr[i] = r_ax[i] + HALF52;
            n_rot[i] = sat32(66'(w_axr[i] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cen <= n_cen;
            r_rot <= n_rot;
        end
    end

    // ---------------------------------------------------------------
    // stages 4-5: axis length squared
    // ---------------------------------------------------------------
    logic signed [63:0] w_asqf [3];
    logic        [62:0] r_asq  [3];
    logic        [63:0] r_asum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_asqf[i] = r_rot[i] * r_rot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_asq[i] <= w_asqf[i][62:0];
            end
            r_asum <= 64'(r_asq[0]) + 64'(r_asq[1]) + 64'(r_asq[2]);
        end
    end

    // ---------------------------------------------------------------
    // column lengths and radius
    // ---------------------------------------------------------------
    logic [31:0] w_clen [3];
    logic [31:0] w_best01;
    logic [31:0] r_best;
    logic [62:0] r_rprod;
    logic [63:0] w_rsum;
    logic [63:0] w_rshift;
    logic [30:0] n_rad;
    logic [30:0] r_rad_dl [DR];

    for (genvar k = 0; k < 3; k++) begin : g_col
        bsct_isqrt #(
            .IN_W (64)
        ) u_col_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (r_cs[k]),
            .o_root (w_clen[k])
        );
    end

    assign w_best01 = (w_clen[1] > w_clen[0]) ? w_clen[1] : w_clen[0];
    assign w_rsum   = 64'(r_rprod) + HALFU;
    assign w_rshift = w_rsum >> FRAC_BITS;
    assign n_rad    = (w_rshift > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : w_rshift[30:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_best      <= (w_clen[2] > w_best01) ? w_clen[2] : w_best01;
            r_rprod     <= 63'(r_lrad) * 63'(r_best);
            r_rad_dl[0] <= n_rad;
            for (int j = 1; j < DR; j++) begin
                r_rad_dl[j] <= r_rad_dl[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // axis normalization
    // ---------------------------------------------------------------
    logic        [31:0] w_alen;
    logic signed [31:0] r_rot_dl [3][DA];
    logic        [31:0] w_abs    [3];
    logic        [DW-1:0] r_dvd  [3];
    logic        [31:0] r_dvs;
    logic        [QW:0] r_flag_dl;
    logic        [QW-1:0] w_quo  [3];
    logic        [31:0] w_q32    [3];
    logic signed [31:0] n_fax    [3];
    logic signed [31:0] r_fax    [3];
    logic signed [31:0] r_cen_dl [3][DC];

    bsct_isqrt #(
        .IN_W (64)
    ) u_axis_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_asum),
        .o_root (w_alen)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_rot_dl[i][TAP][31] ? 32'(-r_rot_dl[i][TAP])
                                            : 32'(r_rot_dl[i][TAP]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rot_dl[i][0] <= r_rot[i];
                for (int j = 1; j < DA; j++) begin
                    r_rot_dl[i][j] <= r_rot_dl[i][j-1];
                end
                // scaled magnitude plus half the divisor: round half away from zero
                r_dvd[i] <= (DW'(w_abs[i]) << FRAC_BITS) + DW'(w_alen >> 1);
                r_cen_dl[i][0] <= r_cen[i];
                for (int j = 1; j < DC; j++) begin
                    r_cen_dl[i][j] <= r_cen_dl[i][j-1];
                end
            end
            r_dvs     <= w_alen;
            r_flag_dl <= {r_flag_dl[QW-1:0], (w_alen > LEN_EPS) && (w_alen != 32'd0)};
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_norm
        bsct_div #(
            .VW (32),
            .QW (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_dvd (r_dvd[i]),
            .i_dvs (r_dvs),
            .o_quo (w_quo[i])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q32[i] = 32'(w_quo[i]);
            if (r_flag_dl[QW]) begin
                n_fax[i] = r_rot_dl[i][DA-1][31] ? -w_q32[i] : w_q32[i];
            end else begin
                n_fax[i] = r_rot_dl[i][DA-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fax <= n_fax;
        end
    end

    // ---------------------------------------------------------------
    // record assembly
    // ---------------------------------------------------------------
    assign w_res = {{OUT_PAD_W{1'b0}}, r_lcos, r_fax[2], r_fax[1], r_fax[0],
                    r_rad_dl[DR-1], r_cen_dl[2][DC-1], r_cen_dl[1][DC-1],
                    r_cen_dl[0][DC-1]};

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for the bounding sphere and normal cone transform.
`timescale 1ns / 1ps

// Scoreboard: predicts one culling record per accepted transform and checks
// records as they leave the block, oldest first.
class cull_record_board;
    localparam int FB = bsct_pkg::FRAC_BITS_DEF;
    localparam longint LEN_EPS = (64'd1 << FB) / 64'd1000000;

    // Mesh-local sphere and cone, as the block holds them.
    logic signed [31:0] centre[3];
    logic        [30:0] radius;
    logic signed [17:0] axis[3];
    logic signed [17:0] cosine;

    logic [bsct_pkg::OUT_TDATA_W-1:0] pending_records[$];
    int mismatches;

    function new();
        mismatches = 0;
        centre = '{0, 0, 0};
        radius = 0;
        axis = '{0, 0, bsct_pkg::AXIS_Z_RST};
        cosine = bsct_pkg::COSINE_RST;
    endfunction

    function void write_reg(bsct_pkg::t_cfg_idx idx, logic [31:0] v);
        case (idx)
            bsct_pkg::CFG_CENTRE_X: centre[0] = v;
            bsct_pkg::CFG_CENTRE_Y: centre[1] = v;
            bsct_pkg::CFG_CENTRE_Z: centre[2] = v;
            bsct_pkg::CFG_RADIUS:   radius = v[30:0];
            bsct_pkg::CFG_AXIS_X:   axis[0] = v[17:0];
            bsct_pkg::CFG_AXIS_Y:   axis[1] = v[17:0];
            bsct_pkg::CFG_AXIS_Z:   axis[2] = v[17:0];
            default:                cosine = v[17:0];
        endcase
    endfunction

    // Round to nearest with ties up, dropping FB fraction bits (128-bit math).
    function logic signed [127:0] round_frac(logic signed [127:0] v);
        return (v + (128'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function logic signed [127:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    function logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] res, bitv;
        res = 0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Note an accepted transform: compute and queue the expected record.
    function void note_transform(logic [bsct_pkg::IN_TDATA_W-1:0] xf);
        logic signed [127:0] m[3][3], tr[3], s, exact, rot[3], len, best, v, q;
        logic [127:0] p, mag;
        logic [bsct_pkg::OUT_TDATA_W-1:0] rec;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                m[k][i] = $signed(xf[(k*3+i)*32 +: 32]);
        for (int i = 0; i < 3; i++) tr[i] = $signed(xf[(9+i)*32 +: 32]);
        rec = '0;
        for (int i = 0; i < 3; i++) begin
            s = tr[i];
            exact = 0;
            for (int k = 0; k < 3; k++) begin
                s += round_frac(m[k][i] * 128'(centre[k]));
                exact += m[k][i] * 128'(axis[k]);
            end
            rec[i*32 +: 32] = clamp32(s);
            rot[i] = clamp32(round_frac(exact));
        end
        best = 0;
        for (int k = 0; k < 3; k++) begin
            len = floor_sqrt(m[k][0]*m[k][0] + m[k][1]*m[k][1] + m[k][2]*m[k][2]);
            if (len > best) best = len;
        end
        p = (128'(radius) * best + (128'd1 << (FB - 1))) >> FB;
        if (p > 128'd2147483647) p = 128'd2147483647;
        rec[96 +: 31] = p[30:0];
        len = floor_sqrt(rot[0]*rot[0] + rot[1]*rot[1] + rot[2]*rot[2]);
        for (int i = 0; i < 3; i++) begin
            v = rot[i];
            if (len > LEN_EPS && len > 0) begin
                mag = (v < 0 ? -v : v) << FB;
                q = (mag + len / 2) / len;
                v = clamp32(v < 0 ? -q : q);
            end
            rec[127 + i*32 +: 32] = v[31:0];
        end
        rec[223 +: 18] = cosine;
        pending_records.push_back(rec);
    endfunction

    function void check_record(logic [bsct_pkg::OUT_TDATA_W-1:0] got);
        logic [bsct_pkg::OUT_TDATA_W-1:0] exp_rec;
        int lsb[9] = '{0, 32, 64, 96, 127, 159, 191, 223, 241};
        int wid[9] = '{32, 32, 32, 31, 32, 32, 32, 18, 7};
        if (pending_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected record %h", got);
            return;
        end
        exp_rec = pending_records.pop_front();
        for (int f = 0; f < 9; f++) begin
            if (((got ^ exp_rec) >> lsb[f]) & ((248'd1 << wid[f]) - 1)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("field %0d: expected %h actual %h", f,
                             (exp_rec >> lsb[f]) & ((248'd1 << wid[f]) - 1),
                             (got >> lsb[f]) & ((248'd1 << wid[f]) - 1));
            end
        end
    endfunction
endclass

module testbench;
    import bsct_pkg::*;

    localparam int LATENCY = FRAC_BITS_DEF + 41;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [IN_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    cull_record_board board = new();
    // Idle percentage per side; zero during the no-idle stretch.
    int idle_pct = 18;
    int idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    bounding_sphere_cone_transform dut (.*);

    // Watchdog: count cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[bounding_sphere_cone_transform] ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, check each record that transfers.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_record(o_m_axis_tdata);
        i_m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // One write, then the write enable drops again so back-to-back writes never collide.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        board.write_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, drain in-flight records, then let the pipeline settle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_records.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offer one transform; hold it until transferred; random gap first.
    // Valid stays high after the transfer; the next gap or drain drops it.
    task automatic send_transform(logic [IN_TDATA_W-1:0] xf);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= xf;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_transform(xf);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(131072)) - 65536);
            3: return 32'($signed($urandom_range(8)) - 4) <<< 16;
            4: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(200000)) - 100000) <<< 4;
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] rand_transform();
        logic [IN_TDATA_W-1:0] xf;
        for (int f = 0; f < 12; f++) xf[f*32 +: 32] = rand_entry();
        return xf;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] fill_transform(logic [31:0] v);
        logic [IN_TDATA_W-1:0] xf;
        for (int f = 0; f < 12; f++) xf[f*32 +: 32] = v;
        return xf;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] identity(logic [31:0] scale);
        logic [IN_TDATA_W-1:0] xf;
        xf = '0;
        xf[0 +: 32] = scale;
        xf[4*32 +: 32] = scale;
        xf[8*32 +: 32] = scale;
        return xf;
    endfunction

    // Load a random local sphere and cone; sometimes extremes.
    task automatic random_config(bit extreme);
        for (int r = 0; r < 8; r++) begin
            logic [31:0] v;
            if (r == CFG_RADIUS || r < 3)
                v = extreme ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000) : rand_entry();
            else if (extreme)
                v = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
            else
                v = $urandom_range(2) == 0 ? $urandom() :
                    32'($signed($urandom_range(131072)) - 65536);
            write_reg(t_cfg_idx'(r), v);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, then extremes and degenerate matrices.
        send_transform(identity(32'h0001_0000));
        send_transform('0);
        send_transform(fill_transform(32'h7FFF_FFFF));
        send_transform(fill_transform(32'h8000_0000));
        send_transform(fill_transform(32'hFFFF_FFFF));
        drain();
        write_reg(CFG_CENTRE_X, 32'h7FFF_FFFF);
        write_reg(CFG_CENTRE_Y, 32'h8000_0000);
        write_reg(CFG_CENTRE_Z, 32'h0001_8000);
        write_reg(CFG_RADIUS, 32'h7FFF_FFFF);
        write_reg(CFG_AXIS_X, 32'h0001_0000);
        write_reg(CFG_AXIS_Y, 32'h0003_0000);
        write_reg(CFG_AXIS_Z, 32'h0000_0001);
        write_reg(CFG_COSINE, 32'h0001_0000);
        send_transform(identity(32'h0001_0000));
        send_transform(identity(32'h7FFF_FFFF));
        send_transform(identity(32'h8000_0000));
        send_transform(identity(32'h0000_0001));   // axis collapses to tiny length
        send_transform('0);
        send_transform(fill_transform(32'h7FFF_FFFF));
        send_transform(fill_transform(32'h8000_0000));
        send_transform(fill_transform(32'h5555_AAAA));
        send_transform(fill_transform(32'hAAAA_5555));
        drain();
        write_reg(CFG_AXIS_X, 32'h0000_0000);
        write_reg(CFG_AXIS_Y, 32'h0000_0000);
        write_reg(CFG_AXIS_Z, 32'h0000_0000);      // zero axis stays unnormalized
        write_reg(CFG_COSINE, 32'hFFFE_0000);
        send_transform(rand_transform());
        send_transform(identity(32'h0002_0000));

        // Random phases, each under fresh configuration.
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            random_config(ph % 4 == 1);
            idle_pct = (ph == 5) ? 0 : 18;
            for (int n = 0; n < 170; n++)
                send_transform(rand_transform());
        end
        idle_pct = 18;
        drain();

        if (board.mismatches == 0 && board.pending_records.size() == 0) begin
            $display("[bounding_sphere_cone_transform] OK");
        end else begin
            $display("[bounding_sphere_cone_transform] ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
src/bsct_pkg.sv
src/bsct_isqrt.sv
src/bsct_div.sv
src/bounding_sphere_cone_transform.sv
tb/testbench.sv
